// ----- sv/lbp_3x3_pixel_stream_unit_macros.svh -----
// Assertion macros shared by the 3x3 LBP stream unit
`ifndef LBP_3X3_PIXEL_STREAM_UNIT_MACROS_SVH
`define LBP_3X3_PIXEL_STREAM_UNIT_MACROS_SVH

// same-cycle implication, checked out of reset
`define LBP_ASSERT_IMP(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked out of reset
`define LBP_ASSERT_NXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- sv/lbp_pkg.sv -----
// Package: shared types, constants and the LBP compare function
`timescale 1ns / 1ps
package lbp_pkg;

  localparam int PIX_W      = 8;
  localparam int ROW_W      = 12;
  localparam int COL_W      = 10;
  localparam int CFG_DATA_W = 13;
  localparam int CFG_IDX_W  = 2;
  localparam int WREG_W     = 11;
  localparam int HREG_W     = 13;
  localparam int RESET_DIM  = 1024;

  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 2'd1;

  localparam int QUEUE_DEPTH = 4;
  localparam int QCW         = $clog2(QUEUE_DEPTH + 1);

  // which results one pixel causes; emitted left, interior, right, own
  typedef struct packed {
    logic done;
    logic own;
    logic right;
    logic interior;
    logic left;
  } lbp_flags_t;

  // neighbor k sets bit k; bit order matches weights 1,2,4,8,16,32,64,128
  function automatic logic [PIX_W-1:0] lbp_code_f(input logic [7:0][PIX_W-1:0] nbr,
                                                  input logic [PIX_W-1:0] ctr);
    logic [PIX_W-1:0] code;
    code = '0;
    for (int k = 0; k < 8; k++) begin
      code[k] = (nbr[k] >= ctr);
    end
    return code;
  endfunction

endpackage

// ----- sv/lbp_ram.sv -----
// Generic single-write, single-read RAM with registered read data
`timescale 1ns / 1ps
module lbp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ----- sv/lbp_front.sv -----
// Front end: pixel intake, position counters, line store, window and result classification
`timescale 1ns / 1ps
module lbp_front import lbp_pkg::*; #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 4096,
  parameter int CW         = $clog2(MAX_WIDTH),
  parameter int RW         = $clog2(MAX_HEIGHT)
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [PIX_W-1:0]      in_pixel_value,
  input  logic [QCW-1:0]        q_count,
  output logic                  push,
  output logic [RW-1:0]         push_row,
  output logic [CW-1:0]         push_col,
  output lbp_flags_t            push_flags,
  output logic [PIX_W-1:0]      push_mid,
  output logic [PIX_W-1:0]      push_pix,
  output logic [PIX_W-1:0]      push_code
);

  localparam int W_RST_M1 = ((RESET_DIM > MAX_WIDTH) ? MAX_WIDTH : RESET_DIM) - 1;
  localparam int H_RST_M1 = ((RESET_DIM > MAX_HEIGHT) ? MAX_HEIGHT : RESET_DIM) - 1;
  localparam int LW       = 2 * PIX_W;

  logic [CW-1:0]    eff_w_m1_r, eff_w_m1_nxt;
  logic [RW-1:0]    eff_h_m1_r, eff_h_m1_nxt;
  logic [CW-1:0]    col_r, col_nxt;
  logic [RW-1:0]    row_r, row_nxt;
  logic             s1_valid_r;
  logic [PIX_W-1:0] s1_pix_r;
  logic [CW-1:0]    s1_col_r;
  logic [RW-1:0]    s1_row_r;
  logic             byp_r, byp_nxt;
  logic [LW-1:0]    byp_data_r;
  logic [PIX_W-1:0] win1_r [3];
  logic [PIX_W-1:0] win2_r [3];
  logic [LW-1:0]    ram_rdata;
  logic [LW-1:0]    line;
  logic [PIX_W-1:0] up;
  logic [PIX_W-1:0] mid;
  logic [7:0][PIX_W-1:0] nbr;
  logic [31:0]      wv;
  logic [31:0]      hv;
  logic             acc;
  logic             r_ge2;
  lbp_flags_t       flags;

  assign in_stall = ({1'b0, q_count} + (QCW+1)'(s1_valid_r)) >= (QCW+1)'(QUEUE_DEPTH);
  assign acc      = in_valid && !in_stall;

  // effective dimensions minus one, saturated
  always_comb begin
    wv           = {{(32-WREG_W){1'b0}}, cfg_wdata[WREG_W-1:0]};
    hv           = {{(32-HREG_W){1'b0}}, cfg_wdata[HREG_W-1:0]};
    eff_w_m1_nxt = eff_w_m1_r;
    eff_h_m1_nxt = eff_h_m1_r;
    if (cfg_we && cfg_index == REG_IMAGE_WIDTH) begin
      if (wv == 32'd0) begin
        eff_w_m1_nxt = '0;
      end else if (wv > 32'(MAX_WIDTH)) begin
        eff_w_m1_nxt = CW'(MAX_WIDTH - 1);
      end else begin
        eff_w_m1_nxt = CW'(wv - 32'd1);
      end
    end
    if (cfg_we && cfg_index == REG_IMAGE_HEIGHT) begin
      if (hv == 32'd0) begin
        eff_h_m1_nxt = '0;
      end else if (hv > 32'(MAX_HEIGHT)) begin
        eff_h_m1_nxt = RW'(MAX_HEIGHT - 1);
      end else begin
        eff_h_m1_nxt = RW'(hv - 32'd1);
      end
    end
  end

  always_comb begin
    col_nxt = col_r;
    row_nxt = row_r;
    if (cfg_we && (cfg_index == REG_IMAGE_WIDTH || cfg_index == REG_IMAGE_HEIGHT)) begin
      col_nxt = '0;
      row_nxt = '0;
    end else if (acc) begin
      if (col_r == eff_w_m1_r) begin
        col_nxt = '0;
        row_nxt = (row_r == eff_h_m1_r) ? '0 : row_r + 1'b1;
      end else begin
        col_nxt = col_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      eff_w_m1_r <= CW'(W_RST_M1);
      eff_h_m1_r <= RW'(H_RST_M1);
      col_r      <= '0;
      row_r      <= '0;
      s1_valid_r <= 1'b0;
      byp_r      <= 1'b0;
    end else begin
      eff_w_m1_r <= eff_w_m1_nxt;
      eff_h_m1_r <= eff_h_m1_nxt;
      col_r      <= col_nxt;
      row_r      <= row_nxt;
      s1_valid_r <= acc;
      byp_r      <= byp_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      s1_pix_r <= in_pixel_value;
      s1_col_r <= col_r;
      s1_row_r <= row_r;
    end
    byp_data_r <= {mid, s1_pix_r};
  end

  // line store entry per column: {row r-2, row r-1}
  lbp_ram #(
    .WIDTH (LW),
    .DEPTH (MAX_WIDTH)
  ) u_line_ram (
    .clk   (clk),
    .we    (s1_valid_r),
    .waddr (s1_col_r),
    .wdata ({mid, s1_pix_r}),
    .raddr (col_r),
    .rdata (ram_rdata)
  );

  // read of the column being written in the same cycle takes the new data
  assign byp_nxt = acc && s1_valid_r && (col_r == s1_col_r);
  assign line    = byp_r ? byp_data_r : ram_rdata;
  assign up      = line[LW-1:PIX_W];
  assign mid     = line[PIX_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 3; i++) begin
        win1_r[i] <= '0;
        win2_r[i] <= '0;
      end
    end else if (s1_valid_r) begin
      for (int i = 0; i < 3; i++) begin
        win1_r[i] <= win2_r[i];
      end
      win2_r[0] <= up;
      win2_r[1] <= mid;
      win2_r[2] <= s1_pix_r;
    end
  end

  always_comb begin
    nbr[0] = win1_r[0];
    nbr[1] = win2_r[0];
    nbr[2] = up;
    nbr[3] = win1_r[1];
    nbr[4] = mid;
    nbr[5] = win1_r[2];
    nbr[6] = win2_r[2];
    nbr[7] = s1_pix_r;
  end

  always_comb begin
    r_ge2          = s1_row_r > RW'(1);
    flags.left     = r_ge2 && (s1_col_r == '0);
    flags.interior = r_ge2 && (s1_col_r > CW'(1));
    flags.right    = r_ge2 && (s1_col_r == eff_w_m1_r) && (eff_w_m1_r != '0);
    flags.own      = (s1_row_r == '0) || (s1_row_r == eff_h_m1_r);
    flags.done     = (s1_row_r == eff_h_m1_r) && (s1_col_r == eff_w_m1_r);
  end

  assign push       = s1_valid_r && (flags.left || flags.interior || flags.right || flags.own);
  assign push_row   = s1_row_r;
  assign push_col   = s1_col_r;
  assign push_flags = flags;
  assign push_mid   = mid;
  assign push_pix   = s1_pix_r;
  assign push_code  = lbp_code_f(nbr, win2_r[1]);

endmodule

// ----- sv/lbp_fifo.sv -----
// Short register queue between front and back ends
`timescale 1ns / 1ps
module lbp_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       push,
  input  logic [WIDTH-1:0]           wr_data,
  input  logic                       pop,
  output logic                       rd_valid,
  output logic [WIDTH-1:0]           rd_data,
  output logic [$clog2(DEPTH+1)-1:0] count
);

`include "lbp_3x3_pixel_stream_unit_macros.svh"

  localparam int AW    = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [AW-1:0]    wp_r, wp_nxt;
  logic [AW-1:0]    rp_r, rp_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;

  always_comb begin
    wp_nxt    = wp_r;
    rp_nxt    = rp_r;
    count_nxt = count_r;
    if (push) begin
      wp_nxt = (wp_r == AW'(DEPTH - 1)) ? '0 : wp_r + 1'b1;
    end
    if (pop) begin
      rp_nxt = (rp_r == AW'(DEPTH - 1)) ? '0 : rp_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r    <= '0;
      rp_r    <= '0;
      count_r <= '0;
    end else begin
      wp_r    <= wp_nxt;
      rp_r    <= rp_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= wr_data;
    end
  end

  assign rd_valid = (count_r != '0);
  assign rd_data  = mem_r[rp_r];
  assign count    = count_r;

  `LBP_ASSERT_IMP(a_no_overflow, push && !pop, count_r != CNT_W'(DEPTH), "queue overflow")
  `LBP_ASSERT_IMP(a_no_underflow, pop, count_r != '0, "pop from empty queue")
  `LBP_ASSERT_NXT(a_count_up, push && !pop, count_r == $past(count_r) + 1'b1, "count mismatch")

endmodule

// ----- sv/lbp_back.sv -----
// Back end: expands one queued pixel into its results and drives the output register
`timescale 1ns / 1ps
module lbp_back import lbp_pkg::*; #(
  parameter int CW = 10,
  parameter int RW = 12
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             q_valid,
  input  logic [RW-1:0]    q_row,
  input  logic [CW-1:0]    q_col,
  input  lbp_flags_t       q_flags,
  input  logic [PIX_W-1:0] q_mid,
  input  logic [PIX_W-1:0] q_pix,
  input  logic [PIX_W-1:0] q_code,
  output logic             q_pop,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [ROW_W-1:0] out_row,
  output logic [COL_W-1:0] out_col,
  output logic [PIX_W-1:0] out_code,
  output logic             out_is_border,
  output logic             out_last_of_run,
  output logic             out_frame_done
);

`include "lbp_3x3_pixel_stream_unit_macros.svh"

  logic [3:0]       done_r, done_nxt;
  logic [3:0]       pend;
  logic [3:0]       pick;
  logic             last;
  logic             load;
  logic             out_valid_r, out_valid_nxt;
  logic [ROW_W-1:0] out_row_r, out_row_nxt;
  logic [COL_W-1:0] out_col_r, out_col_nxt;
  logic [PIX_W-1:0] out_code_r, out_code_nxt;
  logic             out_is_border_r, out_is_border_nxt;
  logic             out_last_of_run_r, out_last_of_run_nxt;
  logic             out_frame_done_r, out_frame_done_nxt;
  logic [RW-1:0]    row_m1;
  logic [CW-1:0]    col_m1;

  // order: left border, interior code, right border, own border copy
  assign pend   = {q_flags.own, q_flags.right, q_flags.interior, q_flags.left} & ~done_r;
  assign pick   = pend & (~pend + 4'd1);
  assign last   = (pend & ~pick) == 4'd0;
  assign load   = q_valid && (!out_valid_r || !out_stall);
  assign q_pop  = load && last;
  assign row_m1 = q_row - 1'b1;
  assign col_m1 = q_col - 1'b1;

  always_comb begin
    done_nxt = done_r;
    if (load) begin
      done_nxt = last ? 4'd0 : (done_r | pick);
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r && out_stall;
    if (load) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_comb begin
    out_row_nxt         = pick[3] ? ROW_W'(q_row) : ROW_W'(row_m1);
    out_col_nxt         = COL_W'(q_col);
    out_code_nxt        = q_mid;
    out_is_border_nxt   = !pick[1];
    out_last_of_run_nxt = last;
    out_frame_done_nxt  = pick[3] && q_flags.done;
    if (pick[0]) begin
      out_col_nxt = '0;
    end else if (pick[1]) begin
      out_col_nxt  = COL_W'(col_m1);
      out_code_nxt = q_code;
    end else if (pick[3]) begin
      out_code_nxt = q_pix;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      done_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      done_r      <= done_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_row_r         <= out_row_nxt;
      out_col_r         <= out_col_nxt;
      out_code_r        <= out_code_nxt;
      out_is_border_r   <= out_is_border_nxt;
      out_last_of_run_r <= out_last_of_run_nxt;
      out_frame_done_r  <= out_frame_done_nxt;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_row         = out_row_r;
  assign out_col         = out_col_r;
  assign out_code        = out_code_r;
  assign out_is_border   = out_is_border_r;
  assign out_last_of_run = out_last_of_run_r;
  assign out_frame_done  = out_frame_done_r;

  `LBP_ASSERT_IMP(a_head_has_work, q_valid, pend != 4'd0, "queued pixel with no result left")
  `LBP_ASSERT_IMP(a_done_is_last, out_valid_r && out_frame_done_r, out_last_of_run_r && out_is_border_r, "frame end not last border")
  `LBP_ASSERT_NXT(a_pop_clears, q_pop, done_r == 4'd0, "result mask not cleared on pop")

endmodule

// ----- sv/lbp_3x3_pixel_stream_unit.sv -----
// Top level: 3x3 local binary pattern over a raster pixel stream
// Throughput: one pixel per cycle unless in_stall; one result per cycle unless out_stall.
// A result's pixel passes the intake register and the queue, then loads the output register.
// Last row pixels cause up to three results each, so the 4-entry queue fills and intake stalls.
// Reset (rst_n low, synchronous): counters, window, queue and out_valid cleared; 1024 x 1024.
// Line store RAM is not cleared: every entry is written before any result reads it.
`timescale 1ns / 1ps
module lbp_3x3_pixel_stream_unit import lbp_pkg::*; #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 4096
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [PIX_W-1:0]      in_pixel_value,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [ROW_W-1:0]      out_row,
  output logic [COL_W-1:0]      out_col,
  output logic [PIX_W-1:0]      out_code,
  output logic                  out_is_border,
  output logic                  out_last_of_run,
  output logic                  out_frame_done
);

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int RW = $clog2(MAX_HEIGHT);
  localparam int FL = $bits(lbp_flags_t);
  localparam int QW = RW + CW + FL + 3 * PIX_W;

  logic             push;
  logic [RW-1:0]    push_row;
  logic [CW-1:0]    push_col;
  lbp_flags_t       push_flags;
  logic [PIX_W-1:0] push_mid;
  logic [PIX_W-1:0] push_pix;
  logic [PIX_W-1:0] push_code;
  logic [QCW-1:0]   q_count;
  logic             q_valid;
  logic             q_pop;
  logic [QW-1:0]    q_wdata;
  logic [QW-1:0]    q_rdata;
  logic [RW-1:0]    q_row;
  logic [CW-1:0]    q_col;
  lbp_flags_t       q_flags;
  logic [PIX_W-1:0] q_mid;
  logic [PIX_W-1:0] q_pix;
  logic [PIX_W-1:0] q_code;

  lbp_front #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT),
    .CW         (CW),
    .RW         (RW)
  ) u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_pixel_value (in_pixel_value),
    .q_count        (q_count),
    .push           (push),
    .push_row       (push_row),
    .push_col       (push_col),
    .push_flags     (push_flags),
    .push_mid       (push_mid),
    .push_pix       (push_pix),
    .push_code      (push_code)
  );

  assign q_wdata = {push_row, push_col, push_flags, push_mid, push_pix, push_code};

  lbp_fifo #(
    .WIDTH (QW),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .wr_data  (q_wdata),
    .pop      (q_pop),
    .rd_valid (q_valid),
    .rd_data  (q_rdata),
    .count    (q_count)
  );

  assign {q_row, q_col, q_flags, q_mid, q_pix, q_code} = q_rdata;

  lbp_back #(
    .CW (CW),
    .RW (RW)
  ) u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .q_valid         (q_valid),
    .q_row           (q_row),
    .q_col           (q_col),
    .q_flags         (q_flags),
    .q_mid           (q_mid),
    .q_pix           (q_pix),
    .q_code          (q_code),
    .q_pop           (q_pop),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_row         (out_row),
    .out_col         (out_col),
    .out_code        (out_code),
    .out_is_border   (out_is_border),
    .out_last_of_run (out_last_of_run),
    .out_frame_done  (out_frame_done)
  );

endmodule

// ----- sim/tb_lbp_3x3_pixel_stream_unit.sv -----
// Self-checking testbench for the 3x3 LBP pixel stream unit
`timescale 1ns / 1ps
module tb_lbp_3x3_pixel_stream_unit;
  import lbp_pkg::*;

  localparam int MAX_W = 1024;
  localparam int MAX_H = 4096;
  localparam int DRAIN_CYCLES = 8;
  localparam int RANDOM_PIXELS = 120;
  localparam int REPORT_LIMIT = 10;

  localparam int PIX_FULL = 0;
  localparam int PIX_NEAR = 1;
  localparam int PIX_RAIL = 2;

  typedef struct packed {
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
    logic [PIX_W-1:0] code;
    logic             border;
    logic             last;
    logic             done;
  } lbp_result_t;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;
  logic                  in_valid;
  logic                  in_stall;
  logic [PIX_W-1:0]      in_pixel_value;
  logic                  out_valid;
  logic                  out_stall;
  logic [ROW_W-1:0]      out_row;
  logic [COL_W-1:0]      out_col;
  logic [PIX_W-1:0]      out_code;
  logic                  out_is_border;
  logic                  out_last_of_run;
  logic                  out_frame_done;

  lbp_3x3_pixel_stream_unit #(
    .MAX_WIDTH (MAX_W),
    .MAX_HEIGHT(MAX_H)
  ) u_top (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_pixel_value (in_pixel_value),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_row        (out_row),
    .out_col        (out_col),
    .out_code       (out_code),
    .out_is_border  (out_is_border),
    .out_last_of_run(out_last_of_run),
    .out_frame_done (out_frame_done)
  );

  // predictor state
  logic [PIX_W-1:0] upper_line [MAX_W];
  logic [PIX_W-1:0] middle_line [MAX_W];
  logic [PIX_W-1:0] win [3][3];
  int unsigned cur_row;
  int unsigned cur_col;
  int unsigned width_reg;
  int unsigned height_reg;

  lbp_result_t pending_lbp_results [$];

  bit calm;
  int pixels_sent;
  int results_seen;
  int cfg_writes;
  int mismatch_count;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("Timeout with %0d results still expected", pending_lbp_results.size());
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  function automatic int unsigned clamp_dim(input int unsigned raw, input int unsigned top);
    if (raw == 0) return 1;
    if (raw > top) return top;
    return raw;
  endfunction

  function automatic logic [PIX_W-1:0] window_code();
    logic [PIX_W-1:0] code;
    int k;
    code = '0;
    k = 0;
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        if (!(i == 1 && j == 1)) begin
          code[k] = (win[i][j] >= win[1][1]);
          k++;
        end
      end
    end
    return code;
  endfunction

  function automatic lbp_result_t make_result(input int unsigned r, input int unsigned c,
                                              input logic [PIX_W-1:0] v, input logic b,
                                              input logic d);
    lbp_result_t res;
    res.row = ROW_W'(r);
    res.col = COL_W'(c);
    res.code = v;
    res.border = b;
    res.last = 1'b0;
    res.done = d;
    return res;
  endfunction

  function automatic logic [PIX_W-1:0] pick_pixel(input int mode);
    case (mode)
      PIX_FULL: return PIX_W'($urandom_range(0, 255));
      PIX_NEAR: return PIX_W'(126 + $urandom_range(0, 3));
      default:  return $urandom_range(0, 1) ? 8'hFF : 8'h00;
    endcase
  endfunction

  task automatic predict_pixel(input logic [PIX_W-1:0] p);
    int unsigned w, h, r, c;
    int n;
    logic [PIX_W-1:0] up, mid;
    lbp_result_t res [3];
    w = clamp_dim(width_reg, MAX_W);
    h = clamp_dim(height_reg, MAX_H);
    r = cur_row;
    c = cur_col;
    if (r >= h) r = 0;
    if (c >= w) c = 0;
    up = upper_line[c];
    mid = middle_line[c];
    upper_line[c] = mid;
    middle_line[c] = p;
    for (int i = 0; i < 3; i++) begin
      win[i][0] = win[i][1];
      win[i][1] = win[i][2];
    end
    win[0][2] = up;
    win[1][2] = mid;
    win[2][2] = p;
    n = 0;
    if (r >= 2) begin
      if (c == 0) begin
        res[n] = make_result(r - 1, 0, mid, 1'b1, 1'b0);
        n++;
      end
      if (c >= 2) begin
        res[n] = make_result(r - 1, c - 1, window_code(), 1'b0, 1'b0);
        n++;
      end
      if (c == w - 1 && w >= 2) begin
        res[n] = make_result(r - 1, c, mid, 1'b1, 1'b0);
        n++;
      end
    end
    if (r == 0 || r == h - 1) begin
      res[n] = make_result(r, c, p, 1'b1, (r == h - 1) && (c == w - 1));
      n++;
    end
    if (n > 0) res[n-1].last = 1'b1;
    for (int i = 0; i < n; i++) pending_lbp_results.push_back(res[i]);
    c++;
    if (c >= w) begin
      c = 0;
      r++;
      if (r >= h) r = 0;
    end
    cur_row = r;
    cur_col = c;
  endtask

  // drive one pixel and hold it until the transfer
  task automatic send_pixel(input logic [PIX_W-1:0] p);
    if (!calm && $urandom_range(0, 99) < 36) begin
      in_valid <= 1'b0;
      do @(posedge clk); while (!calm && $urandom_range(0, 99) < 36);
    end
    in_valid <= 1'b1;
    in_pixel_value <= p;
    predict_pixel(p);
    pixels_sent++;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic wait_results_drained;
    in_valid <= 1'b0;
    while (pending_lbp_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_cfg(input logic [CFG_IDX_W-1:0] idx, input int unsigned value);
    wait_results_drained();
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= CFG_DATA_W'(value);
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_IMAGE_WIDTH) width_reg = value & 32'h7FF;
    else height_reg = value & 32'h1FFF;
    cur_row = 0;
    cur_col = 0;
    cfg_writes++;
  endtask

  task automatic set_dims(input int unsigned w, input int unsigned h);
    write_cfg(REG_IMAGE_WIDTH, w);
    write_cfg(REG_IMAGE_HEIGHT, h);
  endtask

  task automatic check_result_transfer;
    lbp_result_t got, want;
    got = {out_row, out_col, out_code, out_is_border, out_last_of_run, out_frame_done};
    results_seen++;
    if (pending_lbp_results.size() == 0) begin
      mismatch_count++;
      if (mismatch_count <= REPORT_LIMIT)
        $display("Unexpected result: row %0d col %0d code %02h border %0b last %0b done %0b",
                 got.row, got.col, got.code, got.border, got.last, got.done);
    end else begin
      want = pending_lbp_results.pop_front();
      if (got.row !== want.row || got.col !== want.col || got.code !== want.code ||
          got.border !== want.border || got.last !== want.last || got.done !== want.done) begin
        mismatch_count++;
        if (mismatch_count <= REPORT_LIMIT) begin
          $display("Mismatch exp: row %0d col %0d code %02h border %0b last %0b done %0b",
                   want.row, want.col, want.code, want.border, want.last, want.done);
          $display("         got: row %0d col %0d code %02h border %0b last %0b done %0b",
                   got.row, got.col, got.code, got.border, got.last, got.done);
        end
      end
    end
  endtask

  always @(posedge clk) begin
    out_stall <= !calm && ($urandom_range(0, 99) < 36);
    if (rst_n && out_valid && !out_stall) check_result_transfer();
  end

  // reset dimensions, a short run into the first row
  task automatic test_reset_dims;
    for (int k = 0; k < 40; k++) send_pixel(pick_pixel(PIX_FULL));
  endtask

  // 3x3 frames: all equal, alternating rails, neighbors around the center
  task automatic test_code_cases;
    logic [PIX_W-1:0] frames [27];
    frames = '{8'h80, 8'h80, 8'h80, 8'h80, 8'h80, 8'h80, 8'h80, 8'h80, 8'h80,
               8'hFF, 8'h00, 8'hFF, 8'h00, 8'hFF, 8'hFF, 8'h00, 8'hFF, 8'h00,
               8'h00, 8'h01, 8'hFE, 8'h00, 8'h01, 8'h02, 8'h00, 8'h01, 8'h00};
    set_dims(3, 3);
    foreach (frames[k]) send_pixel(frames[k]);
  endtask

  // zero dims, single row or column, two-wide and two-high frames
  task automatic test_small_dims;
    int unsigned dims [6][3];
    dims = '{'{0, 0, 3}, '{1, 2, 4}, '{2, 3, 12}, '{3, 2, 6}, '{2, 1, 4}, '{2, 2, 8}};
    foreach (dims[i]) begin
      set_dims(dims[i][0], dims[i][1]);
      for (int k = 0; k < dims[i][2]; k++) send_pixel(pick_pixel(PIX_FULL));
    end
  endtask

  // a register write in mid-frame restarts the frame
  task automatic test_mid_frame_restart;
    set_dims(5, 6);
    for (int k = 0; k < 13; k++) send_pixel(pick_pixel(PIX_NEAR));
    write_cfg(REG_IMAGE_HEIGHT, 4);
    for (int k = 0; k < 6; k++) send_pixel(pick_pixel(PIX_FULL));
    write_cfg(REG_IMAGE_WIDTH, 4);
    for (int k = 0; k < 16; k++) send_pixel(pick_pixel(PIX_FULL));
  endtask

  // width register above the line store size saturates; no idling here
  task automatic test_widest_rows;
    set_dims(2047, 3);
    calm = 1'b1;
    for (int k = 0; k < 60; k++) send_pixel(pick_pixel(PIX_FULL));
    calm = 1'b0;
  endtask

  // height register saturates; a single column runs down the rows
  task automatic test_tallest_frame;
    set_dims(1, 8191);
    for (int k = 0; k < 40; k++) send_pixel(pick_pixel(PIX_FULL));
  endtask

  task automatic test_random_frames;
    int unsigned w, h, total;
    int sent, mode, sel;
    sent = 0;
    while (sent < RANDOM_PIXELS) begin
      if ($urandom_range(0, 9) == 0) begin
        w = $urandom_range(9, 40);
        h = $urandom_range(1, 3);
      end else begin
        w = $urandom_range(1, 8);
        h = $urandom_range(1, 7);
      end
      sel = $urandom_range(0, 5);
      mode = (sel < 3) ? PIX_FULL : (sel < 5) ? PIX_NEAR : PIX_RAIL;
      set_dims(w, h);
      total = w * h * $urandom_range(1, 2);
      if ($urandom_range(0, 7) == 0) total = $urandom_range(1, w * h);
      if (sent + int'(total) > RANDOM_PIXELS) total = unsigned'(RANDOM_PIXELS - sent);
      calm = ($urandom_range(0, 5) == 0);
      for (int k = 0; k < total; k++) begin
        send_pixel(pick_pixel(mode));
        if ($urandom_range(0, 99) == 0) wait_results_drained();
      end
      calm = 1'b0;
      sent += total;
    end
  endtask

  initial begin
    rst_n <= 1'b0;
    cfg_we <= 1'b0;
    cfg_index <= REG_IMAGE_WIDTH;
    cfg_wdata <= '0;
    in_valid <= 1'b0;
    in_pixel_value <= '0;
    calm = 1'b0;
    for (int i = 0; i < MAX_W; i++) begin
      upper_line[i] = '0;
      middle_line[i] = '0;
    end
    for (int i = 0; i < 3; i++)
      for (int j = 0; j < 3; j++) win[i][j] = '0;
    cur_row = 0;
    cur_col = 0;
    width_reg = RESET_DIM;
    height_reg = RESET_DIM;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    test_reset_dims();
    test_code_cases();
    test_small_dims();
    test_mid_frame_restart();
    test_widest_rows();
    test_tallest_frame();
    test_random_frames();
    wait_results_drained();

    $display("Covered %0d pixel transfers, %0d result transfers, %0d register writes",
             pixels_sent, results_seen, cfg_writes);
    $display("Frames from 1x1 to 40 wide, short runs at reset and saturated sizes; %0d bad results",
             mismatch_count);
    if (mismatch_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
